>>> rtl/core/ctts_pkg.sv
// ctts_pkg: shared types and constants of the tick task scheduler
// item structs, slot struct, cell control struct, operation and status codes
// no dependencies
`timescale 1ns / 1ps

package ctts_pkg;

  localparam int MAX_SLOTS = 16;
  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [7:0] PENDING_MAX = 8'hFF;

  typedef enum logic [1:0] {
    FN_ADD      = 2'd0,
    FN_TICK     = 2'd1,
    FN_DISPATCH = 2'd2,
    FN_DELETE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] task_handle;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic [7:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  result_value;
    logic [15:0] run_handle;
    logic        run_valid;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] countdown;
    logic [15:0] period;
    logic [7:0]  pending;
    logic        valid;
    logic        oneshot;
  } slot_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic tick;
    logic dec;
  } cell_ctl_t;

endpackage

>>> rtl/core/ctts_cell.sv
// ctts_cell: one task slot of the scheduler table
// loads a task, shifts down on removal, counts down on tick, lowers pending on run
// depends on ctts_pkg
`timescale 1ns / 1ps

module ctts_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  ctts_pkg::cell_ctl_t ctl,
  input  ctts_pkg::slot_t     load_slot,
  input  ctts_pkg::slot_t     nbr_slot,
  output ctts_pkg::slot_t     slot_o
);

  ctts_pkg::slot_t slot_r;
  ctts_pkg::slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.load) begin
      slot_nxt = load_slot;
    end else if (ctl.shift) begin
      slot_nxt = nbr_slot;
    end else if (ctl.tick) begin
      if (slot_r.valid && (slot_r.countdown != 16'd0)) begin
        if (slot_r.countdown == 16'd1) begin
          slot_nxt.countdown = slot_r.period;
          if (slot_r.pending != ctts_pkg::PENDING_MAX) begin
            slot_nxt.pending = slot_r.pending + 8'd1;
          end
        end else begin
          slot_nxt.countdown = slot_r.countdown - 16'd1;
        end
      end
    end else if (ctl.dec) begin
      slot_nxt.pending = slot_r.pending - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

>>> rtl/core/cooperative_tick_task_scheduler.sv
// cooperative_tick_task_scheduler: top level, command decode, dispatch scan, result register
// holds a chain of ctts_cell slots that compact toward slot zero
// depends on ctts_pkg and ctts_cell
`timescale 1ns / 1ps

// Usage:
//   An item (in_item) is taken at a clock edge where start is high and busy is low.
//   Results leave on out_item, marked by out_valid for exactly one cycle; the
//   receiver cannot hold them off, out_item.last marks the final result of an item.
//   Add, tick and delete give one result in the cycle after the item is taken and
//   leave busy low, so one of them can be taken every cycle.
//   Dispatch raises busy while a pointer walks the slot chain, one slot per cycle;
//   removing a one-shot task shifts the upper cells down and the same slot is looked
//   at again. The walk ends at the last pending task; each run appears the cycle
//   after its slot is looked at, and busy falls with the final run. With no pending
//   task, busy stays high for one cycle and dispatch gives no result.
//   Tick updates all slots at once, each cell counting its own delay.
//   Reset (rst_n low, synchronous) empties the table and drops any scan.
module cooperative_tick_task_scheduler (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ctts_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output ctts_pkg::out_item_t  out_item
);

  localparam int N = ctts_pkg::MAX_SLOTS;
  localparam int IW = ctts_pkg::IDX_W;
  localparam int CW = ctts_pkg::CNT_W;

  ctts_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic                out_valid_r, out_valid_nxt;
  ctts_pkg::out_item_t out_item_r, out_item_nxt;

  ctts_pkg::slot_t     slots [N];
  ctts_pkg::slot_t     nbrs [N];
  ctts_pkg::cell_ctl_t ctls [N];
  ctts_pkg::slot_t     load_slot;

  logic [N-1:0] pend_mask;
  logic [N-1:0] ge_mask;
  logic [N-1:0] gt_mask;
  logic [N-1:0] valid_vec;
  logic [N-1:0] cnt_mask;
  logic [IW-1:0] ptr_idx;
  logic [IW-1:0] del_idx;
  logic          pend_cur;
  logic          emit;
  logic          emit_last;

  // slot chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == N - 1) begin : g_top
      assign nbrs[g] = '0;
    end else begin : g_mid
      assign nbrs[g] = slots[g + 1];
    end
    ctts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctls[g]),
      .load_slot (load_slot),
      .nbr_slot  (nbrs[g]),
      .slot_o    (slots[g])
    );
  end

  always_comb begin
    for (int j = 0; j < N; j++) begin
      valid_vec[j] = slots[j].valid;
      pend_mask[j] = slots[j].valid && (slots[j].pending != 8'd0);
      ge_mask[j]   = (CW'(j) >= ptr_r);
      gt_mask[j]   = (CW'(j) > ptr_r);
      cnt_mask[j]  = (CW'(j) < count_r);
    end
  end

  assign ptr_idx  = ptr_r[IW-1:0];
  assign del_idx  = in_item.slot_index[IW-1:0];
  assign pend_cur = (ptr_r < CW'(N)) && pend_mask[ptr_idx];

  always_comb begin
    load_slot.handle    = in_item.task_handle;
    load_slot.countdown = in_item.start_delay;
    load_slot.period    = in_item.repeat_period;
    load_slot.pending   = 8'd0;
    load_slot.valid     = 1'b1;
    load_slot.oneshot   = (in_item.repeat_period == 16'd0);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = '0;
    emit          = 1'b0;
    emit_last     = 1'b0;
    for (int j = 0; j < N; j++) begin
      ctls[j] = '0;
    end
    case (state_r)
      ctts_pkg::S_IDLE: begin
        if (start) begin
          case (in_item.func)
            ctts_pkg::FN_ADD: begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.last = 1'b1;
              if (count_r >= CW'(N)) begin
                out_item_nxt.status       = ctts_pkg::STS_FULL;
                out_item_nxt.result_value = 7'(count_r);
              end else begin
                for (int j = 0; j < N; j++) begin
                  ctls[j].load = (count_r == CW'(j));
                end
                count_nxt                 = count_r + CW'(1);
                out_item_nxt.status       = ctts_pkg::STS_OK;
                out_item_nxt.result_value = 7'(count_nxt);
              end
            end
            ctts_pkg::FN_TICK: begin
              for (int j = 0; j < N; j++) begin
                ctls[j].tick = 1'b1;
              end
              out_valid_nxt     = 1'b1;
              out_item_nxt.last = 1'b1;
            end
            ctts_pkg::FN_DISPATCH: begin
              state_nxt = ctts_pkg::S_SCAN;
              ptr_nxt   = '0;
            end
            ctts_pkg::FN_DELETE: begin
              out_valid_nxt     = 1'b1;
              out_item_nxt.last = 1'b1;
              if ((in_item.slot_index < 8'(N)) && (in_item.slot_index < 8'(count_r))
                  && slots[del_idx].valid) begin
                for (int j = 0; j < N; j++) begin
                  ctls[j].shift = (8'(j) >= in_item.slot_index);
                end
                count_nxt                 = count_r - CW'(1);
                out_item_nxt.status       = ctts_pkg::STS_OK;
                out_item_nxt.result_value = 7'(in_item.slot_index);
              end else begin
                out_item_nxt.status = ctts_pkg::STS_BAD;
              end
            end
            default: begin
              state_nxt = ctts_pkg::S_IDLE;
            end
          endcase
        end
      end
      ctts_pkg::S_SCAN: begin
        if ((pend_mask & ge_mask) == '0) begin
          state_nxt = ctts_pkg::S_IDLE;
        end else if (pend_cur) begin
          emit                      = 1'b1;
          emit_last                 = ((pend_mask & gt_mask) == '0);
          out_valid_nxt             = 1'b1;
          out_item_nxt.status       = ctts_pkg::STS_OK;
          out_item_nxt.result_value = 7'(ptr_r);
          out_item_nxt.run_handle   = slots[ptr_idx].handle;
          out_item_nxt.run_valid    = 1'b1;
          out_item_nxt.last         = emit_last;
          if (slots[ptr_idx].oneshot) begin
            for (int j = 0; j < N; j++) begin
              ctls[j].shift = (CW'(j) >= ptr_r);
            end
            count_nxt = count_r - CW'(1);
          end else begin
            ctls[ptr_idx].dec = 1'b1;
            ptr_nxt           = ptr_r + CW'(1);
          end
          if (emit_last) begin
            state_nxt = ctts_pkg::S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ctts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctts_pkg::S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ctts_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(N))
    else $error("task count beyond table size");

  a_compact : assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec == cnt_mask)
    else $error("occupied slots not packed from slot zero");

  a_last_ends_scan : assert property (@(posedge clk) disable iff (!rst_n)
    emit && emit_last |=> state_r == ctts_pkg::S_IDLE)
    else $error("scan continues after final run");

  a_run_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.run_valid |-> out_item_r.status == ctts_pkg::STS_OK)
    else $error("run result with error status");

  a_scan_emits_run : assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r && out_item_r.run_valid)
    else $error("run found but no result shown");

endmodule

>>> verif/cooperative_tick_task_scheduler_test.sv
// cooperative_tick_task_scheduler_test: self-checking bench for the tick task scheduler
// directed and random add, tick, dispatch and delete items checked against a shadow slot table
// depends on ctts_pkg and cooperative_tick_task_scheduler
`timescale 1ns / 1ps

module cooperative_tick_task_scheduler_test;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    ctts_pkg::in_item_t item;
    int unsigned        gap;
    bit                 drain;
  } cmd_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ctts_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  ctts_pkg::out_item_t out_item;

  cooperative_tick_task_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow of the slot table
  ctts_pkg::slot_t     shadow_slots [ctts_pkg::MAX_SLOTS];
  int unsigned         shadow_count;

  ctts_pkg::out_item_t results_due[$];
  cmd_req_t            cmd_q[$];
  cmd_req_t            cur_cmd;
  bit                  have_cmd = 1'b0;
  int unsigned         gap_cnt = 0;
  int unsigned         n_predicted = 0;
  int unsigned         n_seen = 0;
  int unsigned         n_err = 0;
  int unsigned         stall_cnt = 0;
  bit                  no_idle = 1'b0;

  function automatic ctts_pkg::out_item_t make_result(logic [1:0] sts, int unsigned value,
                                                      logic [15:0] hnd, logic rv);
    ctts_pkg::out_item_t r;
    r.status       = sts;
    r.result_value = 7'(value);
    r.run_handle   = hnd;
    r.run_valid    = rv;
    r.last         = 1'b0;
    return r;
  endfunction

  task automatic close_gap(input int unsigned idx);
    int unsigned i;
    for (i = idx; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i + 1];
    shadow_slots[shadow_count - 1] = '0;
    shadow_count--;
  endtask

  task automatic schedule_step(input ctts_pkg::in_item_t cmd);
    ctts_pkg::out_item_t batch[$];
    ctts_pkg::out_item_t r;
    int unsigned         idx;
    int unsigned         s;
    bit                  removed;
    case (ctts_pkg::func_t'(cmd.func))
      ctts_pkg::FN_ADD: begin
        if (shadow_count >= ctts_pkg::MAX_SLOTS) begin
          batch.push_back(make_result(ctts_pkg::STS_FULL, shadow_count, 16'd0, 1'b0));
        end else begin
          shadow_slots[shadow_count].handle    = cmd.task_handle;
          shadow_slots[shadow_count].countdown = cmd.start_delay;
          shadow_slots[shadow_count].period    = cmd.repeat_period;
          shadow_slots[shadow_count].pending   = 8'd0;
          shadow_slots[shadow_count].valid     = 1'b1;
          shadow_slots[shadow_count].oneshot   = (cmd.repeat_period == 16'd0);
          shadow_count++;
          batch.push_back(make_result(ctts_pkg::STS_OK, shadow_count, 16'd0, 1'b0));
        end
      end
      ctts_pkg::FN_TICK: begin
        for (s = 0; s < ctts_pkg::MAX_SLOTS; s++) begin
          if (shadow_slots[s].valid && shadow_slots[s].countdown != 16'd0) begin
            shadow_slots[s].countdown--;
            if (shadow_slots[s].countdown == 16'd0) begin
              if (shadow_slots[s].pending < ctts_pkg::PENDING_MAX) shadow_slots[s].pending++;
              shadow_slots[s].countdown = shadow_slots[s].period;
            end
          end
        end
        batch.push_back(make_result(ctts_pkg::STS_OK, 0, 16'd0, 1'b0));
      end
      ctts_pkg::FN_DISPATCH: begin
        idx = 0;
        while (idx < shadow_count) begin
          removed = 1'b0;
          if (shadow_slots[idx].valid && shadow_slots[idx].pending != 8'd0) begin
            shadow_slots[idx].pending--;
            batch.push_back(make_result(ctts_pkg::STS_OK, idx, shadow_slots[idx].handle,
                                        1'b1));
            // removed one-shot: the task shifted into this slot is looked at next
            if (shadow_slots[idx].oneshot) begin
              close_gap(idx);
              removed = 1'b1;
            end
          end
          if (!removed) idx++;
        end
      end
      default: begin
        if (cmd.slot_index >= ctts_pkg::MAX_SLOTS || cmd.slot_index >= shadow_count ||
            !shadow_slots[cmd.slot_index].valid) begin
          batch.push_back(make_result(ctts_pkg::STS_BAD, 0, 16'd0, 1'b0));
        end else begin
          close_gap(cmd.slot_index);
          batch.push_back(make_result(ctts_pkg::STS_OK, cmd.slot_index, 16'd0, 1'b0));
        end
      end
    endcase
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[k]) results_due.push_back(batch[k]);
    n_predicted += batch.size();
  endtask

  // driver
  always @(posedge clk) begin
    logic nxt_start;
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
      shadow_count = 0;
      for (int s = 0; s < ctts_pkg::MAX_SLOTS; s++) shadow_slots[s] = '0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        schedule_step(in_item);
        nxt_start = 1'b0;
        have_cmd  = 1'b0;
      end
      if (!nxt_start) begin
        if (!have_cmd && cmd_q.size() > 0) begin
          cur_cmd  = cmd_q.pop_front();
          have_cmd = 1'b1;
          gap_cnt  = cur_cmd.gap;
        end
        if (have_cmd) begin
          if (cur_cmd.drain && !(n_predicted == n_seen + out_valid && !busy)) begin
          end else if (gap_cnt > 0) begin
            gap_cnt--;
          end else begin
            nxt_start = 1'b1;
            in_item <= cur_cmd.item;
          end
        end
      end
      start <= nxt_start;
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    ctts_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      n_seen <= n_seen + 1;
      if (results_due.size() == 0) begin
        $error("result with no item outstanding: value %0d handle %0d",
               out_item.result_value, out_item.run_handle);
        n_err++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("result_value", want.result_value, out_item.result_value);
        check_field("run_handle", want.run_handle, out_item.run_handle);
        check_field("run_valid", want.run_valid, out_item.run_valid);
        check_field("last", want.last, out_item.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic ctts_pkg::in_item_t make_cmd(ctts_pkg::func_t fn);
    ctts_pkg::in_item_t it;
    it.func          = fn;
    it.task_handle   = 16'($urandom);
    it.start_delay   = 16'($urandom);
    it.repeat_period = 16'($urandom);
    it.slot_index    = 8'($urandom);
    return it;
  endfunction

  function automatic ctts_pkg::in_item_t make_add(logic [15:0] hnd, logic [15:0] dly,
                                                  logic [15:0] per);
    ctts_pkg::in_item_t it;
    it = make_cmd(ctts_pkg::FN_ADD);
    it.task_handle   = hnd;
    it.start_delay   = dly;
    it.repeat_period = per;
    return it;
  endfunction

  function automatic ctts_pkg::in_item_t make_delete(logic [7:0] idx);
    ctts_pkg::in_item_t it;
    it = make_cmd(ctts_pkg::FN_DELETE);
    it.slot_index = idx;
    return it;
  endfunction

  task automatic queue_cmd(input ctts_pkg::in_item_t it, input bit drain);
    cmd_req_t rq;
    rq.item  = it;
    rq.gap   = no_idle ? 0 : $urandom_range(0, 7);
    rq.drain = drain;
    cmd_q.push_back(rq);
  endtask

  function automatic logic [15:0] pick_time(int unsigned hi);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, hi));
  endfunction

  initial begin
    int unsigned        sel;
    ctts_pkg::in_item_t it;

    // directed: empty table, one-shots, compaction during dispatch, full table
    queue_cmd(make_cmd(ctts_pkg::FN_DISPATCH), 1'b0);
    queue_cmd(make_delete(8'hFF), 1'b0);
    queue_cmd(make_add(16'hFFFF, 16'd1, 16'd0), 1'b0);
    queue_cmd(make_add(16'h0000, 16'd0, 16'd0), 1'b0);
    queue_cmd(make_add(16'h1234, 16'd2, 16'd1), 1'b0);
    queue_cmd(make_add(16'hA5A5, 16'hFFFF, 16'hFFFF), 1'b0);
    queue_cmd(make_add(16'h5A5A, 16'd1, 16'd0), 1'b0);
    queue_cmd(make_cmd(ctts_pkg::FN_TICK), 1'b0);
    queue_cmd(make_cmd(ctts_pkg::FN_TICK), 1'b0);
    queue_cmd(make_cmd(ctts_pkg::FN_DISPATCH), 1'b0);
    queue_cmd(make_delete(8'd3), 1'b0);
    for (int k = 0; k < 14; k++) begin
      queue_cmd(make_add(16'($urandom), pick_time(5), pick_time(3)), 1'b0);
    end
    queue_cmd(make_add(16'h7777, 16'd1, 16'd1), 1'b0);
    queue_cmd(make_delete(8'(ctts_pkg::MAX_SLOTS - 1)), 1'b0);
    queue_cmd(make_delete(8'(ctts_pkg::MAX_SLOTS)), 1'b0);

    // random traffic, some items held back until the table has answered everything
    queue_cmd(make_cmd(ctts_pkg::FN_TICK), 1'b1);
    for (int k = 0; k < 200; k++) begin
      if (k % 25 == 0) no_idle = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        it = make_add(16'($urandom), pick_time(6), pick_time(4));
      end else if (sel < 70) begin
        it = make_cmd(ctts_pkg::FN_TICK);
      end else if (sel < 85) begin
        it = make_cmd(ctts_pkg::FN_DISPATCH);
      end else begin
        it = make_delete(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 17)));
      end
      queue_cmd(it, $urandom_range(0, 39) == 0);
    end

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (cmd_q.size() > 0 || have_cmd || start || busy || results_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_err == 0 && results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> cooperative_tick_task_scheduler.f
rtl/core/ctts_pkg.sv
rtl/core/ctts_cell.sv
rtl/core/cooperative_tick_task_scheduler.sv
verif/cooperative_tick_task_scheduler_test.sv
